### hdl/prcs_pkg.sv
package prcs_pkg;

   // Default histogram length
   localparam int BIN_COUNT_DEF = 64;

   // Fixed field widths
   localparam int VALUE_W  = 16;
   localparam int HELD_W   = 7;
   localparam int CENTER_W = 6;

   // Register port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [VALUE_W-1:0] target_level;
      logic [VALUE_W-1:0] band_tolerance;
   } cfg_type;

   // Write strobes and band flag towards the run store
   typedef struct packed {
      logic band_we;
      logic run_we;
      logic band_bit;
   } store_ctl_type;

endpackage

### hdl/prcs_if.sv
interface req_if;
   import prcs_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [VALUE_W-1:0]       bin_value;
   logic signed [HELD_W-1:0] held_index;
   logic                     last_bin;

   modport source (output valid, output bin_value, output held_index, output last_bin,
                   input ready);
   modport sink   (input valid, input bin_value, input held_index, input last_bin,
                   output ready);
endinterface

interface rsp_if;
   import prcs_pkg::*;

   logic                valid;
   logic                ready;
   logic [CENTER_W-1:0] center_index;

   modport source (output valid, output center_index, input ready);
   modport sink   (input valid, input center_index, output ready);
endinterface

### hdl/prcs_csr.sv
module prcs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [prcs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [prcs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [prcs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output prcs_pkg::cfg_type             cfg
);
   import prcs_pkg::*;

   typedef enum logic [0:0] {
      REG_TARGET,
      REG_TOLERANCE
   } reg_idx_type;

   logic [VALUE_W-1:0] target_ff, target_in;
   logic [VALUE_W-1:0] tol_ff, tol_in;
   reg_idx_type        reg_idx;
   logic               wr_fire;

   // Registers sit on 4-byte boundaries
   assign reg_idx    = reg_idx_type'(csr_paddr[2]);
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Decode the write transaction
   always_comb begin
      target_in = target_ff;
      tol_in    = tol_ff;
      if (wr_fire) begin
         unique case (reg_idx)
            REG_TARGET:    target_in = csr_pwdata[VALUE_W-1:0];
            REG_TOLERANCE: tol_in    = csr_pwdata[VALUE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         tol_ff    <= '0;
      end else begin
         target_ff <= target_in;
         tol_ff    <= tol_in;
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (reg_idx)
         REG_TARGET:    csr_prdata = CSR_DATA_W'(target_ff);
         REG_TOLERANCE: csr_prdata = CSR_DATA_W'(tol_ff);
      endcase
   end

   assign cfg.target_level   = target_ff;
   assign cfg.band_tolerance = tol_ff;

endmodule

### hdl/prcs_store.sv
module prcs_store #(
   parameter int BIN_COUNT = prcs_pkg::BIN_COUNT_DEF,
   parameter int IDX_W     = $clog2(BIN_COUNT),
   parameter int LEN_W     = $clog2(BIN_COUNT + 1)
) (
   input  logic                   clock,
   input  prcs_pkg::store_ctl_type wr_ctl,
   input  logic [IDX_W-1:0]       wr_idx,
   input  logic [IDX_W-1:0]       wr_start,
   input  logic [LEN_W-1:0]       wr_len,
   input  logic [IDX_W-1:0]       rd_idx,
   input  logic [IDX_W-1:0]       rd_start_addr,
   output logic                   rd_band,
   output logic [IDX_W-1:0]       rd_start,
   output logic [LEN_W-1:0]       rd_len
);
   import prcs_pkg::*;

   logic             band_mem  [BIN_COUNT];
   logic [IDX_W-1:0] start_mem [BIN_COUNT];
   logic [LEN_W-1:0] len_mem   [BIN_COUNT];

   // Per-bin flag and run start, per-start run length
   always_ff @(posedge clock) begin
      if (wr_ctl.band_we) begin
         band_mem[wr_idx] <= wr_ctl.band_bit;
      end
      if (wr_ctl.run_we) begin
         start_mem[wr_idx]  <= wr_start;
         len_mem[wr_start]  <= wr_len;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      rd_band  <= band_mem[rd_idx];
      rd_start <= start_mem[rd_idx];
      rd_len   <= len_mem[rd_start_addr];
   end

endmodule

### hdl/prcs_core.sv
module prcs_core #(
   parameter int BIN_COUNT = prcs_pkg::BIN_COUNT_DEF,
   parameter int IDX_W     = $clog2(BIN_COUNT),
   parameter int LEN_W     = $clog2(BIN_COUNT + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  prcs_pkg::cfg_type       cfg,
   req_if.sink                     req_bus,
   rsp_if.source                   rsp_bus,
   output prcs_pkg::store_ctl_type wr_ctl,
   output logic [IDX_W-1:0]        wr_idx,
   output logic [IDX_W-1:0]        wr_start,
   output logic [LEN_W-1:0]        wr_len,
   output logic [IDX_W-1:0]        rd_idx,
   output logic [IDX_W-1:0]        rd_start_addr,
   input  logic                    rd_band,
   input  logic [IDX_W-1:0]        rd_start,
   input  logic [LEN_W-1:0]        rd_len
);
   import prcs_pkg::*;

   localparam int CMP_W = (LEN_W > HELD_W) ? LEN_W : HELD_W;
   localparam int SUM_W = LEN_W + 1;
   localparam int RES_W = (SUM_W > CENTER_W) ? SUM_W : CENTER_W;

   typedef enum logic [2:0] {
      S_STREAM,
      S_LOOK_BIN,
      S_LOOK_RUN,
      S_PICK,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic                in_vld_ff, in_vld_in;
   logic [VALUE_W-1:0]  in_bin_ff;
   logic [HELD_W-1:0]   in_held_ff;
   logic                in_last_ff;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]    cur_start_ff, cur_start_in;
   logic [LEN_W-1:0]    cur_len_ff, cur_len_in;
   logic                inside_ff, inside_in;
   logic [IDX_W-1:0]    best_start_ff, best_start_in;
   logic [LEN_W-1:0]    best_len_ff, best_len_in;
   logic [LEN_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    held_addr_ff, held_addr_in;
   logic                held_ok_ff, held_ok_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [CENTER_W-1:0] rsp_center_ff, rsp_center_in;

   logic                accept;
   logic                end_hist;
   logic [VALUE_W-1:0]  bin_gap;
   logic                in_band;
   logic [IDX_W-1:0]    run_start_new;
   logic [LEN_W-1:0]    run_len_new;
   logic [CMP_W-1:0]    held_cmp;
   logic [SUM_W-1:0]    end_sum;
   logic                keep_held;
   logic [RES_W-1:0]    result;

   // Hold off new bins while a histogram end is being resolved
   assign end_hist      = in_last_ff || (cnt_ff == IDX_W'(BIN_COUNT - 1));
   assign req_bus.ready = (state_ff == S_STREAM) && !(in_vld_ff && end_hist);
   assign accept        = req_bus.valid && req_bus.ready;

   // Band test on the registered bin
   assign bin_gap = (in_bin_ff >= cfg.target_level) ? in_bin_ff - cfg.target_level
                                                    : cfg.target_level - in_bin_ff;
   assign in_band = bin_gap <= cfg.band_tolerance;

   assign run_start_new = inside_ff ? cur_start_ff : cnt_ff;
   assign run_len_new   = inside_ff ? cur_len_ff + LEN_W'(1) : LEN_W'(1);

   // Store writes for the bin in the input register
   assign wr_ctl.band_we  = in_vld_ff;
   assign wr_ctl.run_we   = in_vld_ff && in_band;
   assign wr_ctl.band_bit = in_band;
   assign wr_idx          = cnt_ff;
   assign wr_start        = run_start_new;
   assign wr_len          = run_len_new;

   // Lookup addresses: held bin first, then the start of its run
   assign rd_idx        = held_addr_ff;
   assign rd_start_addr = rd_start;

   assign held_cmp = CMP_W'(in_held_ff);

   assign keep_held = held_ok_ff && rd_band &&
                      (SUM_W'(rd_len) <= SUM_W'(best_len_ff) + SUM_W'(1)) &&
                      (SUM_W'(best_len_ff) <= SUM_W'(rd_len) + SUM_W'(1));

   // Edge or centre of the chosen run, or zero when no bin was in band
   assign end_sum = SUM_W'(best_start_ff) + SUM_W'(best_len_ff);
   always_comb begin
      if ((best_len_ff == '0) || (best_start_ff == '0)) begin
         result = '0;
      end else if (end_sum == SUM_W'(count_ff)) begin
         result = RES_W'(count_ff) - RES_W'(1);
      end else begin
         result = RES_W'(best_start_ff) + RES_W'(best_len_ff >> 1);
      end
   end

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      in_vld_in     = accept;
      cnt_in        = cnt_ff;
      cur_start_in  = cur_start_ff;
      cur_len_in    = cur_len_ff;
      inside_in     = inside_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      count_in      = count_ff;
      held_addr_in  = held_addr_ff;
      held_ok_in    = held_ok_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp_bus.ready;
      rsp_center_in = rsp_center_ff;

      unique case (state_ff)
         S_STREAM: begin
            if (in_vld_ff) begin
               if (in_band) begin
                  cur_start_in = run_start_new;
                  cur_len_in   = run_len_new;
                  if (run_len_new > best_len_ff) begin
                     best_start_in = run_start_new;
                     best_len_in   = run_len_new;
                  end
               end
               inside_in = in_band;
               if (end_hist) begin
                  count_in     = LEN_W'(cnt_ff) + LEN_W'(1);
                  held_ok_in   = !in_held_ff[HELD_W-1] &&
                                 (held_cmp < CMP_W'(LEN_W'(cnt_ff) + LEN_W'(1)));
                  held_addr_in = held_cmp[IDX_W-1:0];
                  state_in     = S_LOOK_BIN;
               end else begin
                  cnt_in = cnt_ff + IDX_W'(1);
               end
            end
         end
         S_LOOK_BIN: state_in = S_LOOK_RUN;
         S_LOOK_RUN: state_in = S_PICK;
         S_PICK: begin
            if (keep_held) begin
               best_start_in = rd_start;
               best_len_in   = rd_len;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            // Wait for the result slot, then clear for the next histogram
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in    = 1'b1;
               rsp_center_in = result[CENTER_W-1:0];
               cnt_in        = '0;
               cur_start_in  = '0;
               cur_len_in    = '0;
               inside_in     = 1'b0;
               best_start_in = '0;
               best_len_in   = '0;
               state_in      = S_STREAM;
            end
         end
         default: state_in = S_STREAM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_STREAM;
         in_vld_ff     <= 1'b0;
         cnt_ff        <= '0;
         cur_start_ff  <= '0;
         cur_len_ff    <= '0;
         inside_ff     <= 1'b0;
         best_start_ff <= '0;
         best_len_ff   <= '0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_vld_ff     <= in_vld_in;
         cnt_ff        <= cnt_in;
         cur_start_ff  <= cur_start_in;
         cur_len_ff    <= cur_len_in;
         inside_ff     <= inside_in;
         best_start_ff <= best_start_in;
         best_len_ff   <= best_len_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
      count_ff      <= count_in;
      held_addr_ff  <= held_addr_in;
      held_ok_ff    <= held_ok_in;
      rsp_center_ff <= rsp_center_in;
      if (accept) begin
         in_bin_ff  <= req_bus.bin_value;
         in_held_ff <= req_bus.held_index;
         in_last_ff <= req_bus.last_bin;
      end
   end

   assign rsp_bus.valid        = rsp_vld_ff;
   assign rsp_bus.center_index = rsp_center_ff;

endmodule

### hdl/plateau_run_center_select.sv
// Throughput: one bin per cycle while a histogram streams in.
// After the transaction carrying the final bin, the core steps through S_LOOK_BIN,
// S_LOOK_RUN, S_PICK and S_DONE (held-bin lookup in the run store), and S_DONE waits
// for a free result slot; input ready stays low until the result is registered.
// Reset (synchronous, active high) clears run tracking, handshake state and the
// registers; the run store is not cleared and needs no clearing pass.
module plateau_run_center_select #(
   parameter int BIN_COUNT = prcs_pkg::BIN_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   req_if.sink                             req_bus,
   rsp_if.source                           rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prcs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [prcs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [prcs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import prcs_pkg::*;

   localparam int IDX_W = $clog2(BIN_COUNT);
   localparam int LEN_W = $clog2(BIN_COUNT + 1);

   cfg_type          cfg;
   store_ctl_type    wr_ctl;
   logic [IDX_W-1:0] wr_idx;
   logic [IDX_W-1:0] wr_start;
   logic [LEN_W-1:0] wr_len;
   logic [IDX_W-1:0] rd_idx;
   logic [IDX_W-1:0] rd_start_addr;
   logic             rd_band;
   logic [IDX_W-1:0] rd_start;
   logic [LEN_W-1:0] rd_len;

   prcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   prcs_store #(
      .BIN_COUNT (BIN_COUNT),
      .IDX_W     (IDX_W),
      .LEN_W     (LEN_W)
   ) u_store (
      .clock         (clock),
      .wr_ctl        (wr_ctl),
      .wr_idx        (wr_idx),
      .wr_start      (wr_start),
      .wr_len        (wr_len),
      .rd_idx        (rd_idx),
      .rd_start_addr (rd_start_addr),
      .rd_band       (rd_band),
      .rd_start      (rd_start),
      .rd_len        (rd_len)
   );

   prcs_core #(
      .BIN_COUNT (BIN_COUNT),
      .IDX_W     (IDX_W),
      .LEN_W     (LEN_W)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .wr_ctl        (wr_ctl),
      .wr_idx        (wr_idx),
      .wr_start      (wr_start),
      .wr_len        (wr_len),
      .rd_idx        (rd_idx),
      .rd_start_addr (rd_start_addr),
      .rd_band       (rd_band),
      .rd_start      (rd_start),
      .rd_len        (rd_len)
   );

endmodule

### hdl/prcs_checker.sv
module prcs_checker #(
   parameter int BIN_COUNT = prcs_pkg::BIN_COUNT_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [prcs_pkg::CENTER_W-1:0] rsp_center
);
   import prcs_pkg::*;

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_center))
      else $error("result changed while stalled");

   // Drop ready straight after the final bin of a histogram
   a_end_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("input accepted during end-of-histogram lookup");

   // A fresh result only follows a lookup phase
   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a lookup phase");

   // Selected bin lies inside the histogram
   a_center_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_center) < BIN_COUNT))
      else $error("center index beyond histogram");

endmodule

bind plateau_run_center_select prcs_checker #(
   .BIN_COUNT (BIN_COUNT)
) u_prcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_last   (req_bus.last_bin),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_center (rsp_bus.center_index)
);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import prcs_pkg::*;

   // Register map and stimulus constants
   localparam logic [CSR_ADDR_W-1:0] TARGET_ADDR = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] TOL_ADDR    = 3'd4;
   localparam int HIST_BINS    = BIN_COUNT_DEF;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 8;
   localparam int PHASE_BINS   = 62;

   localparam logic [HELD_W-1:0] NO_HELD       = 7'h7F;
   localparam logic [HELD_W-1:0] MOST_NEG_HELD = 7'h40;
   localparam logic [HELD_W-1:0] TOP_HELD      = 7'h3F;

   localparam logic [VALUE_W-1:0] DIR_LEVEL = 16'h8000;
   localparam logic [VALUE_W-1:0] DIR_TOL   = 16'h0100;
   localparam logic [VALUE_W-1:0] BAND_LOW  = 16'h7F00;
   localparam logic [VALUE_W-1:0] BAND_HIGH = 16'h8100;
   localparam logic [VALUE_W-1:0] JUST_OUT  = 16'h8101;
   localparam logic [VALUE_W-1:0] MID       = 16'h8000;
   localparam logic [VALUE_W-1:0] FLOOR     = 16'h0000;
   localparam logic [VALUE_W-1:0] CEILING   = 16'hFFFF;

   typedef struct packed {
      logic [VALUE_W-1:0]  bin;
      logic [HELD_W-1:0]   held;
      logic                closing;
      logic                fixed;
      logic [CENTER_W-1:0] centre;
   } bin_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int  cycles = 0;
   bit  failed = 1'b0;
   int  burst_left = 0;
   int  stall_mode = 0;
   logic [7:0] stall_phase = '0;
   logic [CENTER_W-1:0] centre_due;

   // Shadow of the block: band registers and run tracking
   cfg_type band_cfg = '0;
   bit  band_flag [HIST_BINS];
   int  run_head  [HIST_BINS];
   int  run_span  [HIST_BINS];
   int  cur_head = 0;
   int  cur_span = 0;
   bit  in_run = 1'b0;
   int  best_head = 0;
   int  best_span = 0;
   int  bins_seen = 0;

   // Centre indices still owed by the block, oldest first
   logic [CENTER_W-1:0] centre_q [$];

   // Directed histograms, each closed by a final bin
   bin_row_type plan [23] = '{
      // longest run in the middle
      '{FLOOR,     7'h00,         1'b0, 1'b0, 6'd0},
      '{MID,       7'h00,         1'b0, 1'b0, 6'd0},
      '{MID,       7'h00,         1'b0, 1'b0, 6'd0},
      '{MID,       7'h00,         1'b0, 1'b0, 6'd0},
      '{CEILING,   7'h00,         1'b0, 1'b0, 6'd0},
      '{MID,       NO_HELD,       1'b1, 1'b0, 6'd0},
      // run reaching the final bin, band edges exactly
      '{CEILING,   7'h00,         1'b0, 1'b0, 6'd0},
      '{BAND_LOW,  7'h00,         1'b0, 1'b0, 6'd0},
      '{MID,       7'h00,         1'b0, 1'b0, 6'd0},
      '{BAND_HIGH, NO_HELD,       1'b1, 1'b1, 6'd3},
      // nothing in band, held index past the histogram
      '{FLOOR,     7'h00,         1'b0, 1'b0, 6'd0},
      '{CEILING,   TOP_HELD,      1'b1, 1'b1, 6'd0},
      // held run one shorter than the longest is kept
      '{FLOOR,     7'h00,         1'b0, 1'b0, 6'd0},
      '{MID,       7'h00,         1'b0, 1'b0, 6'd0},
      '{MID,       7'h00,         1'b0, 1'b0, 6'd0},
      '{CEILING,   7'h00,         1'b0, 1'b0, 6'd0},
      '{BAND_LOW,  7'h00,         1'b0, 1'b0, 6'd0},
      '{BAND_HIGH, 7'h00,         1'b0, 1'b0, 6'd0},
      '{MID,       7'h00,         1'b0, 1'b0, 6'd0},
      '{JUST_OUT,  7'h02,         1'b1, 1'b0, 6'd0},
      // negative held index other than minus one
      '{JUST_OUT,  7'h00,         1'b0, 1'b0, 6'd0},
      '{MID,       MOST_NEG_HELD, 1'b1, 1'b0, 6'd0},
      // single bin run starting at zero
      '{MID,       7'h00,         1'b1, 1'b1, 6'd0}
   };

   req_if req_bus ();
   rsp_if rsp_bus ();

   plateau_run_center_select #(
      .BIN_COUNT (HIST_BINS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   // Advance the shadow by one bin; return 1 with the centre when the histogram closes
   function automatic bit predict_centre(input logic [VALUE_W-1:0] bin,
                                         input logic [HELD_W-1:0] held,
                                         input bit closing,
                                         output logic [CENTER_W-1:0] centre);
      int idx;
      int level_gap;
      int count;
      int head;
      int span;
      int pick;
      idx = (bins_seen >= HIST_BINS) ? HIST_BINS - 1 : bins_seen;
      level_gap = (bin >= band_cfg.target_level) ?
                  int'(bin) - int'(band_cfg.target_level) :
                  int'(band_cfg.target_level) - int'(bin);
      if (level_gap <= int'(band_cfg.band_tolerance)) begin
         if (!in_run) begin
            in_run   = 1'b1;
            cur_head = idx;
            cur_span = 0;
         end
         cur_span++;
         run_head[idx]      = cur_head;
         run_span[cur_head] = cur_span;
         if (cur_span > best_span) begin
            best_span = cur_span;
            best_head = cur_head;
         end
         band_flag[idx] = 1'b1;
      end else begin
         in_run         = 1'b0;
         band_flag[idx] = 1'b0;
      end
      if (!closing && idx != HIST_BINS - 1) begin
         bins_seen = idx + 1;
         return 1'b0;
      end
      count = idx + 1;
      // hysteresis: keep the held run if it is within one bin of the longest
      if (!held[HELD_W-1] && int'(held) < count && band_flag[held]) begin
         head = run_head[held];
         span = run_span[head];
         if (span <= best_span + 1 && best_span <= span + 1) begin
            best_head = head;
            best_span = span;
         end
      end
      if (best_span == 0 || best_head == 0)
         pick = 0;
      else if (best_head + best_span == count)
         pick = count - 1;
      else
         pick = best_head + best_span / 2;
      centre = pick[CENTER_W-1:0];
      cur_head  = 0;
      cur_span  = 0;
      in_run    = 1'b0;
      best_head = 0;
      best_span = 0;
      bins_seen = 0;
      return 1'b1;
   endfunction

   // Offer one bin, with bursts and gaps, and log its centre once accepted
   task automatic send_bin(input logic [VALUE_W-1:0] bin, input logic [HELD_W-1:0] held,
                           input bit closing, input bit fixed,
                           input logic [CENTER_W-1:0] fixed_centre);
      int gap;
      logic [CENTER_W-1:0] centre;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
                      $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.bin_value  <= bin;
      req_bus.held_index <= held;
      req_bus.last_bin   <= closing;
      do @(posedge clock); while (!req_bus.ready);
      if (predict_centre(bin, held, closing, centre))
         centre_q.push_back(fixed ? fixed_centre : centre);
   endtask

   // One register transaction: setup, then access until pready
   task automatic csr_cycle(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] wdata,
                            output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write both band registers, read them back and update the shadow
   task automatic program_band(input logic [VALUE_W-1:0] level,
                               input logic [VALUE_W-1:0] tol);
      logic [CSR_DATA_W-1:0] rd;
      csr_cycle(1'b1, TARGET_ADDR, CSR_DATA_W'(level), rd);
      csr_cycle(1'b1, TOL_ADDR, CSR_DATA_W'(tol), rd);
      csr_cycle(1'b0, TARGET_ADDR, '0, rd);
      if (rd[VALUE_W-1:0] !== level) begin
         $error("target_level: expected %h, got %h", level, rd[VALUE_W-1:0]);
         failed = 1'b1;
      end
      csr_cycle(1'b0, TOL_ADDR, '0, rd);
      if (rd[VALUE_W-1:0] !== tol) begin
         $error("band_tolerance: expected %h, got %h", tol, rd[VALUE_W-1:0]);
         failed = 1'b1;
      end
      band_cfg.target_level   = level;
      band_cfg.band_tolerance = tol;
   endtask

   // Result side: stall on a pattern that changes mode whenever stall_phase[6:0] wraps to zero
   always @(posedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      case (stall_mode)
         0: begin
            rsp_bus.ready <= 1'b1;
         end
         1: begin
            rsp_bus.ready <= ($urandom_range(0, 1) == 0);
         end
         2: begin
            rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_bus.ready <= (stall_phase[2:0] < 3'd3);
         end
      endcase
      if (stall_phase[6:0] == 7'd0)
         stall_mode <= $urandom_range(0, 3);
   end

   // Compare every result transaction with the oldest owed centre
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (centre_q.size() == 0) begin
            $error("center_index: expected none, got %0d", rsp_bus.center_index);
            failed = 1'b1;
         end else begin
            centre_due = centre_q.pop_front();
            if (rsp_bus.center_index !== centre_due) begin
               $error("center_index: expected %0d, got %0d", centre_due,
                      rsp_bus.center_index);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      int phase;
      int phase_bins;
      int span;
      int lo;
      int hi;
      int roll;
      bit want_in;
      bit closing;
      logic [VALUE_W-1:0] level;
      logic [VALUE_W-1:0] tol;
      logic [VALUE_W-1:0] bin;
      logic [HELD_W-1:0]  held;

      // hold every input at a known value through reset
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_bus.valid      = 1'b0;
      req_bus.bin_value  = '0;
      req_bus.held_index = '0;
      req_bus.last_bin   = 1'b0;
      rsp_bus.ready      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_band(DIR_LEVEL, DIR_TOL);
      foreach (plan[i])
         send_bin(plan[i].bin, plan[i].held, plan[i].closing, plan[i].fixed,
                  plan[i].centre);

      for (phase = 0; phase <= PHASES; phase++) begin
         // drop valid, drain owed centres and let the block settle
         req_bus.valid <= 1'b0;
         while (centre_q.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         if (phase == PHASES)
            break;

         case (phase)
            0: begin
               level = '0;
               tol   = '0;
            end
            1: begin
               level = '1;
               tol   = '1;
            end
            2: begin
               level = '1;
               tol   = '0;
            end
            3: begin
               level = '0;
               tol   = '1;
            end
            default: begin
               level = VALUE_W'($urandom);
               tol   = ($urandom_range(0, 1) == 0) ? VALUE_W'($urandom_range(0, 255)) :
                       VALUE_W'($urandom_range(0, 16'h3000));
            end
         endcase
         program_band(level, tol);
         lo = (int'(level) > int'(tol)) ? int'(level) - int'(tol) : 0;
         hi = (int'(level) + int'(tol) < 65535) ? int'(level) + int'(tol) : 65535;

         // histograms of runs: mostly short, some long, a few at full length
         phase_bins = 0;
         while (phase_bins < PHASE_BINS) begin
            roll = $urandom_range(0, 19);
            span = (roll == 0) ? HIST_BINS :
                   (roll < 3) ? $urandom_range(17, HIST_BINS - 1) : $urandom_range(1, 16);
            want_in = 1'($urandom_range(0, 1));
            for (int k = 0; k < span; k++) begin
               if ($urandom_range(0, 3) == 0)
                  want_in = !want_in;
               roll = $urandom_range(0, 99);
               if (roll < 10)
                  bin = VALUE_W'($urandom);
               else if (want_in)
                  bin = (roll < 20) ? VALUE_W'(lo) : (roll < 30) ? VALUE_W'(hi) :
                        VALUE_W'($urandom_range(hi, lo));
               else if (lo > 0 && (hi == 65535 || roll < 65))
                  bin = (roll < 40) ? VALUE_W'(lo - 1) : VALUE_W'($urandom_range(lo - 1, 0));
               else if (hi < 65535)
                  bin = (roll < 75) ? VALUE_W'(hi + 1) :
                        VALUE_W'($urandom_range(65535, hi + 1));
               else
                  bin = VALUE_W'($urandom);
               // a full-length histogram may also close by bin count alone
               closing = (k == span - 1) && (span < HIST_BINS || $urandom_range(0, 1) == 1);
               roll = $urandom_range(0, 99);
               if (roll < 50)
                  held = HELD_W'($urandom_range(0, k));
               else if (roll < 65)
                  held = NO_HELD;
               else if (roll < 75)
                  held = HELD_W'($urandom_range(64, 127));
               else if (roll < 85)
                  held = HELD_W'($urandom_range(63, k + 1));
               else
                  held = HELD_W'($urandom);
               send_bin(bin, held, closing, 1'b0, '0);
               phase_bins++;
            end
         end
      end

      if (!failed)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### plateau_run_center_select.f
hdl/prcs_pkg.sv
hdl/prcs_if.sv
hdl/prcs_csr.sv
hdl/prcs_store.sv
hdl/prcs_core.sv
hdl/plateau_run_center_select.sv
hdl/prcs_checker.sv
tb/sv/tb.sv
